// ===== src/mar_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mar_pkg
// Shared constants and controller/datapath command and status types for the
// moving average ring.
// ----------------------------------------------------------------------------
package mar_pkg;

  localparam int WINDOW_LENGTH_DEF = 32;
  localparam int DATA_W            = 16;
  localparam int AVG_W             = 24;
  localparam int CNT_W             = 6;

  typedef struct packed {
    logic capture;
    logic upd;
    logic fill_wr;
    logic div_load;
    logic div_step;
    logic out_load;
  } mar_cmd_t;

  typedef struct packed {
    logic fill_last;
    logic div_last;
  } mar_sts_t;

endpackage

// ===== src/mar_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mar_ctrl
// Sequencer for the moving average ring: window sweep, sample update,
// iterative divide and output register handoff.
// ----------------------------------------------------------------------------
module mar_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_operation,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output mar_pkg::mar_cmd_t cmd,
  input  mar_pkg::mar_sts_t sts
);
  import mar_pkg::*;

  typedef enum logic [2:0] {
    ST_FILL,
    ST_IDLE,
    ST_UPD,
    ST_LOAD,
    ST_DIV,
    ST_FIN
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   accept;
  logic   out_free;

  assign accept    = in_valid && (state_r == ST_IDLE);
  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || !out_stall;

  always_comb begin
    cmd          = '0;
    cmd.capture  = accept;
    cmd.fill_wr  = (state_r == ST_FILL);
    cmd.upd      = (state_r == ST_UPD);
    cmd.div_load = (state_r == ST_LOAD);
    cmd.div_step = (state_r == ST_DIV);
    cmd.out_load = (state_r == ST_FIN) && out_free;
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      ST_FILL: begin
        if (sts.fill_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_nxt = in_operation ? ST_FILL : ST_UPD;
        end
      end
      ST_UPD:  state_nxt = ST_LOAD;
      ST_LOAD: state_nxt = ST_DIV;
      ST_DIV: begin
        if (sts.div_last) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // reset starts with a clearing sweep of the window
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_FILL;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== src/mar_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mar_dp
// Datapath: window memory, running sum, write position, restoring divider
// and output registers.
// ----------------------------------------------------------------------------
module mar_dp #(
  parameter int WINDOW_LENGTH = mar_pkg::WINDOW_LENGTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  mar_pkg::mar_cmd_t                  cmd,
  output mar_pkg::mar_sts_t                  sts,
  input  logic                               in_operation,
  input  logic signed [mar_pkg::DATA_W-1:0]  in_value,
  output logic signed [mar_pkg::AVG_W-1:0]   out_average,
  output logic        [mar_pkg::CNT_W-1:0]   out_count_used
);
  import mar_pkg::*;

  localparam int PW    = (WINDOW_LENGTH > 1) ? $clog2(WINDOW_LENGTH) : 1;
  localparam int CW    = $clog2(WINDOW_LENGTH + 1);
  localparam int SUM_W = DATA_W + 1 + $clog2(WINDOW_LENGTH);
  localparam int QW    = SUM_W + 8;
  localparam int DCW   = $clog2(QW);

  logic        [DATA_W-1:0] mem [WINDOW_LENGTH];
  logic signed [DATA_W-1:0] rd_data_r;
  logic signed [DATA_W-1:0] x_r;

  logic signed [SUM_W-1:0]  sum_r, sum_nxt;
  logic        [PW-1:0]     pos_r, pos_nxt;
  logic                     full_r, full_nxt;
  logic        [PW-1:0]     fill_cnt_r;
  logic        [CW-1:0]     denom_r, denom_nxt;
  logic        [PW:0]       pos_inc;
  logic                     pos_wrap;

  logic        [QW-1:0]     q_r;
  logic        [CW-1:0]     rem_r;
  logic                     neg_r;
  logic        [DCW-1:0]    div_cnt_r;
  logic        [SUM_W-1:0]  mag;
  logic        [CW:0]       rem_sh;
  logic        [CW:0]       rem_diff;
  logic                     ge;
  logic        [QW-1:0]     avg_full;
  logic        [CW+CNT_W-1:0] den_ext;

  assign pos_inc  = {1'b0, pos_r} + (PW+1)'(1);
  assign pos_wrap = (pos_inc == (PW+1)'(WINDOW_LENGTH));

  always_comb begin
    sum_nxt   = sum_r;
    pos_nxt   = pos_r;
    full_nxt  = full_r;
    denom_nxt = denom_r;
    if (cmd.capture && in_operation) begin
      sum_nxt  = SUM_W'(in_value) * SUM_W'(WINDOW_LENGTH);
      pos_nxt  = '0;
      full_nxt = (in_value != '0);
    end else if (cmd.upd) begin
      sum_nxt = sum_r - SUM_W'(rd_data_r) + SUM_W'(x_r);
      if (pos_wrap) begin
        pos_nxt   = '0;
        full_nxt  = 1'b1;
        denom_nxt = CW'(WINDOW_LENGTH);
      end else begin
        pos_nxt   = pos_inc[PW-1:0];
        denom_nxt = full_r ? CW'(WINDOW_LENGTH) : CW'(pos_inc);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r      <= '0;
      pos_r      <= '0;
      full_r     <= 1'b0;
      fill_cnt_r <= '0;
      x_r        <= '0;
    end else begin
      sum_r  <= sum_nxt;
      pos_r  <= pos_nxt;
      full_r <= full_nxt;
      if (cmd.capture) begin
        x_r <= in_value;
      end
      if (cmd.fill_wr) begin
        fill_cnt_r <= sts.fill_last ? '0 : fill_cnt_r + PW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    denom_r <= denom_nxt;
  end

  // window memory
  always_ff @(posedge clk) begin
    if (cmd.fill_wr) begin
      mem[fill_cnt_r] <= x_r;
    end else if (cmd.upd) begin
      mem[pos_r] <= x_r;
    end
    rd_data_r <= mem[pos_r];
  end

  assign sts.fill_last = (fill_cnt_r == PW'(WINDOW_LENGTH - 1));
  assign sts.div_last  = (div_cnt_r == DCW'(QW - 1));

  // restoring divider, one quotient bit per cycle
  assign mag      = sum_r[SUM_W-1] ? SUM_W'(-sum_r) : SUM_W'(sum_r);
  assign rem_sh   = {rem_r, q_r[QW-1]};
  assign rem_diff = rem_sh - {1'b0, denom_r};
  assign ge       = (rem_sh >= {1'b0, denom_r});

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      q_r       <= {mag, 8'd0};
      rem_r     <= '0;
      neg_r     <= sum_r[SUM_W-1];
      div_cnt_r <= '0;
    end else if (cmd.div_step) begin
      q_r       <= {q_r[QW-2:0], ge};
      rem_r     <= ge ? rem_diff[CW-1:0] : rem_sh[CW-1:0];
      div_cnt_r <= div_cnt_r + DCW'(1);
    end
  end

  assign avg_full = neg_r ? (~q_r + QW'(1)) : q_r;
  assign den_ext  = {{CNT_W{1'b0}}, denom_r};

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_average    <= avg_full[AVG_W-1:0];
      out_count_used <= den_ext[CNT_W-1:0];
    end
  end

endmodule

// ===== src/moving_average_ring.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// moving_average_ring
// Sliding-window mean over a ring of signed samples with a running sum and
// an iterative divider; refill loads the whole window with one value.
// ----------------------------------------------------------------------------
// divider: each sample's average comes from the bit-serial divider, SUM_W + 8 steps
// throughput: a new sample or refill is accepted only once the previous one has
//   finished; a refill sweeps the window, one memory write per cycle
// reset: synchronous; a clearing sweep of the window follows reset,
//   input stalled until it ends
module moving_average_ring #(
  parameter int WINDOW_LENGTH = mar_pkg::WINDOW_LENGTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_operation,
  input  logic signed [mar_pkg::DATA_W-1:0] in_value,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [mar_pkg::AVG_W-1:0]  out_average,
  output logic        [mar_pkg::CNT_W-1:0]  out_count_used
);
  import mar_pkg::*;

  mar_cmd_t cmd;
  mar_sts_t sts;

  mar_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_operation (in_operation),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .cmd          (cmd),
    .sts          (sts)
  );

  mar_dp #(
    .WINDOW_LENGTH (WINDOW_LENGTH)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_operation   (in_operation),
    .in_value       (in_value),
    .out_average    (out_average),
    .out_count_used (out_count_used)
  );

endmodule

// ===== test/tb_moving_average_ring.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_moving_average_ring
// Self-checking bench for the sliding-window averager. Samples and refills
// are sent over the valid/stall input channel. A behavioral model of the
// ring, running sum and divisor predicts each average. Every output
// transaction is compared against the oldest prediction. Both channels idle
// at random, and the bench also runs a long output hold-off and pauses that
// let the block drain.
// ----------------------------------------------------------------------------
module tb_moving_average_ring;
  import mar_pkg::*;

  localparam int  WIN          = WINDOW_LENGTH_DEF;
  localparam int  LATENCY      = 33;
  localparam int  DRAIN_CYCLES = 2 * LATENCY + WIN;
  localparam int  IDLE_LIMIT   = 3000;
  localparam int  LONG_HOLD    = 400;
  localparam logic OP_SAMPLE   = 1'b0;
  localparam logic OP_REFILL   = 1'b1;

  typedef struct packed {
    logic [AVG_W-1:0] average;
    logic [CNT_W-1:0] count_used;
  } mean_t;

  logic                     clk;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_stall;
  logic                     in_operation;
  logic signed [DATA_W-1:0] in_value;
  logic                     out_valid;
  logic                     out_stall;
  logic signed [AVG_W-1:0]  out_average;
  logic        [CNT_W-1:0]  out_count_used;

  logic signed [DATA_W-1:0] win_mem [WIN];
  longint                   win_sum;
  int                       win_pos;
  bit                       win_full;

  mean_t mean_q[$];
  int    errors = 0;
  int    idle_cycles = 0;
  int    rx_hold;
  bit    tx_idle;
  bit    rx_idle;

  moving_average_ring #(.WINDOW_LENGTH(WIN)) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_operation   (in_operation),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_average    (out_average),
    .out_count_used (out_count_used)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // ring model: returns 1 when the operation produces an average
  function automatic bit update_window(input logic op, input logic signed [DATA_W-1:0] val,
                                       output mean_t res);
    longint denom;
    longint scaled;
    res = '0;
    if (op == OP_REFILL) begin
      foreach (win_mem[i]) win_mem[i] = val;
      win_sum  = longint'(val) * WIN;
      win_pos  = 0;
      win_full = (val != 0);
      return 1'b0;
    end
    win_sum = win_sum - longint'(win_mem[win_pos]) + longint'(val);
    win_mem[win_pos] = val;
    win_pos++;
    if (win_pos >= WIN) begin
      win_pos  = 0;
      win_full = 1'b1;
    end
    denom = win_full ? WIN : win_pos;
    if (denom < 1) denom = 1;
    scaled = (win_sum * 256) / denom;
    res.average    = scaled[AVG_W-1:0];
    res.count_used = denom[CNT_W-1:0];
    return 1'b1;
  endfunction

  function automatic logic signed [DATA_W-1:0] rand_value();
    case ($urandom_range(0, 7))
      0:       return 16'sh7fff;
      1:       return 16'sh8000;
      2:       return DATA_W'($signed($urandom_range(0, 15)) - 8);
      default: return DATA_W'($urandom);
    endcase
  endfunction

  task automatic send_op(input logic op, input logic signed [DATA_W-1:0] val);
    int    gap;
    mean_t res;
    gap = tx_idle ? $urandom_range(0, 13) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_operation <= op;
    in_value     <= val;
    do @(posedge clk); while (in_stall);
    if (update_window(op, val, res)) mean_q.push_back(res);
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (mean_q.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    send_op(OP_SAMPLE, 16'sh7fff);
    send_op(OP_SAMPLE, 16'sh8000);
    send_op(OP_SAMPLE, 16'sh0000);
    send_op(OP_SAMPLE, 16'sh0001);
    send_op(OP_SAMPLE, -16'sd1);
    send_op(OP_SAMPLE, 16'sh5555);
    send_op(OP_SAMPLE, 16'shaaaa);
    send_op(OP_SAMPLE, -16'sd3);
    // full window of max, then min
    send_op(OP_REFILL, 16'sh7fff);
    send_op(OP_SAMPLE, 16'sh7fff);
    send_op(OP_SAMPLE, 16'sh8000);
    send_op(OP_REFILL, 16'sh8000);
    send_op(OP_SAMPLE, 16'sh8000);
    send_op(OP_SAMPLE, 16'sh7fff);
    // zero refill leaves the window not full
    send_op(OP_REFILL, 16'sh0000);
    send_op(OP_SAMPLE, -16'sd7);
    send_op(OP_SAMPLE, 16'sd2);
    send_op(OP_REFILL, 16'sh0001);
    send_op(OP_SAMPLE, 16'sh0000);
    send_op(OP_REFILL, -16'sd1);
    send_op(OP_REFILL, 16'sh1234);
    send_op(OP_SAMPLE, 16'sh0000);
    wait_drain();
  endtask

  task automatic test_wrap();
    send_op(OP_REFILL, 16'sh0000);
    repeat (WIN + 8) send_op(OP_SAMPLE, rand_value());
    wait_drain();
  endtask

  task automatic test_random(input int n_items);
    repeat (n_items) begin
      if ($urandom_range(0, 23) == 0)
        send_op(OP_REFILL, ($urandom_range(0, 3) == 0) ? 16'sh0000 : rand_value());
      else
        send_op(OP_SAMPLE, rand_value());
    end
  endtask

  task automatic test_backpressure();
    tx_idle = 1'b0;
    rx_hold = LONG_HOLD;
    test_random(60);
    tx_idle = 1'b1;
    wait_drain();
  endtask

  task automatic test_no_idle();
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    test_random(80);
    tx_idle = 1'b1;
    rx_idle = 1'b1;
  endtask

  initial begin : receiver
    int n;
    out_stall <= 1'b0;
    @(posedge clk);
    forever begin
      if (rx_hold > 0) begin
        n = rx_hold;
        rx_hold = 0;
      end else begin
        n = rx_idle ? $urandom_range(0, 13) : 0;
      end
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  always @(posedge clk) begin : check_results
    mean_t exp_r;
    if (rst_n && out_valid && !out_stall) begin
      if (mean_q.size() == 0) begin
        $display("%0t: unexpected transaction, average %0d count %0d", $time,
                 out_average, out_count_used);
        errors++;
      end else begin
        exp_r = mean_q.pop_front();
        if (out_average !== exp_r.average) begin
          $display("%0t: average mismatch, expected %0d actual %0d", $time,
                   $signed(exp_r.average), out_average);
          errors++;
        end
        if (out_count_used !== exp_r.count_used) begin
          $display("%0t: count_used mismatch, expected %0d actual %0d", $time,
                   exp_r.count_used, out_count_used);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: watchdog expired", $time);
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    rx_hold      = 0;
    tx_idle      = 1'b1;
    rx_idle      = 1'b1;
    win_sum      = 0;
    win_pos      = 0;
    win_full     = 1'b0;
    foreach (win_mem[i]) win_mem[i] = '0;
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_operation <= OP_SAMPLE;
    in_value     <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_wrap();
    test_random(250);
    test_backpressure();
    test_no_idle();
    test_random(250);

    wait_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
